// ----- rtl/wsrm_pkg.sv -----
package wsrm_pkg;

  localparam int unsigned ActionWidth = 2;
  localparam int unsigned IndexWidth  = 5;
  localparam int unsigned SymWidth    = 8;
  localparam int unsigned LenWidth    = 6;

  typedef enum logic [ActionWidth-1:0] {
    ACT_WRITE_PATTERN = 2'd0,
    ACT_BEGIN_TEXT    = 2'd1,
    ACT_TEXT_SYMBOL   = 2'd2,
    ACT_UNUSED        = 2'd3
  } action_e;

  localparam logic [SymWidth-1:0] SYM_ANY  = 8'h2E;
  localparam logic [SymWidth-1:0] SYM_STAR = 8'h2A;

endpackage

// ----- rtl/wsrm_in_if.sv -----
interface wsrm_in_if;
  logic                                valid;
  logic                                ready;
  logic [wsrm_pkg::ActionWidth-1:0]    action;
  logic [wsrm_pkg::IndexWidth-1:0]     pattern_index;
  logic [wsrm_pkg::SymWidth-1:0]       symbol;

  modport source (output valid, output action, output pattern_index, output symbol,
                  input ready);
  modport sink (input valid, input action, input pattern_index, input symbol,
                output ready);
endinterface

// ----- rtl/wsrm_out_if.sv -----
interface wsrm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

// ----- rtl/wsrm_cfg_if.sv -----
interface wsrm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wsrm_pkg::LenWidth-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/wildcard_star_regex_matcher.sv -----
// A begin or text request passes a start state and then steps through the L positions
// of the pattern in use (L is the pattern length), as one compare unit walks the pattern
// one position per cycle. A pattern write is stored when it is accepted.
// Throughput: one request at a time; the next is taken once the result is delivered.
// Reset clears the length register and the match row; pattern bytes are undefined
// until written.
module wildcard_star_regex_matcher #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsrm_cfg_if.sink     cfg_i,
  wsrm_in_if.sink      in_i,
  wsrm_out_if.source   out_o
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [wsrm_pkg::LenWidth-1:0]   len_cfg_q;
  logic [LW-1:0]                   used_len;
  logic [LW-1:0]                   pos_q, pos_d;
  logic [MAX_PATTERN:0]            row_q, row_d;
  logic                            first_q, first_d;
  logic [wsrm_pkg::SymWidth-1:0]   sym_q, sym_d;
  logic                            old_prev_q, old_prev_d;
  logic                            new_m1_q, new_m1_d;
  logic                            new_m2_q, new_m2_d;
  logic [wsrm_pkg::SymWidth-1:0]   prev_pat_q, prev_pat_d;
  logic                            matched_q, matched_d;
  logic [wsrm_pkg::SymWidth-1:0]   mem [MAX_PATTERN];
  logic [wsrm_pkg::SymWidth-1:0]   rd_q;
  logic [AW-1:0]                   rd_addr;
  logic                            in_fire;
  logic                            mem_we;
  logic                            next_bit;
  logic                            fits_cur;
  logic                            fits_prev;

  assign cfg_i.ready   = (state_q == S_IDLE);
  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = (state_q == S_OUT);
  assign out_o.matched = matched_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign mem_we   = in_fire && (in_i.action == wsrm_pkg::ACT_WRITE_PATTERN) &&
                    (32'(in_i.pattern_index) < MAX_PATTERN);
  assign used_len = (32'(len_cfg_q) > MAX_PATTERN) ? LW'(MAX_PATTERN) : LW'(len_cfg_q);
  assign rd_addr  = (state_q == S_STEP) ? pos_q[AW-1:0] : '0;

  assign fits_cur  = (rd_q == wsrm_pkg::SYM_ANY) || (rd_q == sym_q);
  assign fits_prev = (prev_pat_q == wsrm_pkg::SYM_ANY) || (prev_pat_q == sym_q);

  always_comb begin
    if (rd_q != wsrm_pkg::SYM_STAR) begin
      next_bit = !first_q && old_prev_q && fits_cur;
    end else if (pos_q > LW'(1)) begin
      next_bit = new_m2_q || (!first_q && row_q[pos_q] && fits_prev);
    end else begin
      next_bit = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    row_d      = row_q;
    first_d    = first_q;
    sym_d      = sym_q;
    old_prev_d = old_prev_q;
    new_m1_d   = new_m1_q;
    new_m2_d   = new_m2_q;
    prev_pat_d = prev_pat_q;
    matched_d  = matched_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_i.action == wsrm_pkg::ACT_BEGIN_TEXT ||
                        in_i.action == wsrm_pkg::ACT_TEXT_SYMBOL)) begin
          first_d = (in_i.action == wsrm_pkg::ACT_BEGIN_TEXT);
          sym_d   = in_i.symbol;
          state_d = S_START;
        end
      end
      S_START: begin
        for (int i = 1; i <= MAX_PATTERN; i++) begin
          if (i > int'(used_len)) begin
            row_d[i] = 1'b0;
          end
        end
        row_d[0]   = first_q;
        old_prev_d = row_q[0];
        new_m1_d   = first_q;
        new_m2_d   = 1'b0;
        pos_d      = LW'(1);
        if (used_len == '0) begin
          matched_d = first_q;
          state_d   = S_OUT;
        end else begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        row_d[pos_q] = next_bit;
        old_prev_d   = row_q[pos_q];
        new_m2_d     = new_m1_q;
        new_m1_d     = next_bit;
        prev_pat_d   = rd_q;
        if (pos_q == used_len) begin
          matched_d = next_bit;
          state_d   = S_OUT;
        end else begin
          pos_d = pos_q + LW'(1);
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_cfg_q <= '0;
      row_q     <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      if (cfg_i.valid && cfg_i.ready) begin
        len_cfg_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    first_q    <= first_d;
    sym_q      <= sym_d;
    old_prev_q <= old_prev_d;
    new_m1_q   <= new_m1_d;
    new_m2_q   <= new_m2_d;
    prev_pat_q <= prev_pat_d;
    matched_q  <= matched_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(in_i.pattern_index)] <= in_i.symbol;
    end
    rd_q <= mem[rd_addr];
  end

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready && !cfg_i.ready)
    else $error("request accepted while a result is pending");

  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(state_q) == S_STEP || $past(state_q) == S_START))
    else $error("result raised without a pattern walk");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (pos_q != '0 && pos_q <= used_len))
    else $error("pattern position out of range");

  a_step_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && pos_q != used_len) |=> (state_q == S_STEP &&
      pos_q == $past(pos_q) + LW'(1)))
    else $error("pattern walk skipped a position");

endmodule
